// ----- rtl/cp1252_mojibake_utf8_to_utf16_top_defines.svh -----
// Assertion macros shared by the transcoder modules.
`ifndef CP1252_MOJIBAKE_UTF8_TO_UTF16_TOP_DEFINES_SVH
`define CP1252_MOJIBAKE_UTF8_TO_UTF16_TOP_DEFINES_SVH

// Property that must hold at every clock outside reset.
`define CPM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same-cycle implication.
`define CPM_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CPM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/cp_moji_pkg.sv -----
// Shared types, constants and the CP1252 reverse map for the transcoder.
package cp_moji_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [2:0] SEQ_SIZE_2 = 3'd2;
   localparam logic [2:0] SEQ_SIZE_3 = 3'd3;
   localparam logic [2:0] SEQ_SIZE_4 = 3'd4;

   localparam logic [7:0] LEAD2_MIN = 8'hc2;
   localparam logic [7:0] LEAD2_MAX = 8'hdf;
   localparam logic [7:0] LEAD3_MIN = 8'he0;
   localparam logic [7:0] LEAD3_MAX = 8'hef;
   localparam logic [7:0] LEAD4_MIN = 8'hf0;
   localparam logic [7:0] LEAD4_MAX = 8'hf4;

   localparam logic [20:0] MIN_3BYTE = 21'h000800;
   localparam logic [20:0] MIN_4BYTE = 21'h010000;
   localparam logic [20:0] SURR_LO   = 21'h00d800;
   localparam logic [20:0] SURR_HI   = 21'h00dfff;
   localparam logic [20:0] MAX_POINT = 21'h10ffff;
   localparam logic [15:0] HI_SURR_BASE = 16'hd800;
   localparam logic [15:0] LO_SURR_BASE = 16'hdc00;

   // One queue entry: everything one accepted beat produces.
   typedef struct packed {
      logic [1:0]  n_units;
      logic [15:0] unit0;
      logic [15:0] unit1;
      logic        has_status;
      logic        accepted;
   } entry_type;

   // Returns {valid, byte}.
   function automatic logic [8:0] unit_to_byte(input logic [15:0] u);
      logic [8:0] r;
      r = 9'd0;
      if (u[15:8] == 8'h00) begin
         r = {1'b1, u[7:0]};
      end else begin
         unique case (u)
            16'h20ac: r = {1'b1, 8'h80};
            16'h201a: r = {1'b1, 8'h82};
            16'h0192: r = {1'b1, 8'h83};
            16'h201e: r = {1'b1, 8'h84};
            16'h2026: r = {1'b1, 8'h85};
            16'h2020: r = {1'b1, 8'h86};
            16'h2021: r = {1'b1, 8'h87};
            16'h02c6: r = {1'b1, 8'h88};
            16'h2030: r = {1'b1, 8'h89};
            16'h0160: r = {1'b1, 8'h8a};
            16'h2039: r = {1'b1, 8'h8b};
            16'h0152: r = {1'b1, 8'h8c};
            16'h017d: r = {1'b1, 8'h8e};
            16'h2018: r = {1'b1, 8'h91};
            16'h2019: r = {1'b1, 8'h92};
            16'h201c: r = {1'b1, 8'h93};
            16'h201d: r = {1'b1, 8'h94};
            16'h2022: r = {1'b1, 8'h95};
            16'h2013: r = {1'b1, 8'h96};
            16'h2014: r = {1'b1, 8'h97};
            16'h02dc: r = {1'b1, 8'h98};
            16'h2122: r = {1'b1, 8'h99};
            16'h0161: r = {1'b1, 8'h9a};
            16'h203a: r = {1'b1, 8'h9b};
            16'h0153: r = {1'b1, 8'h9c};
            16'h017e: r = {1'b1, 8'h9e};
            16'h0178: r = {1'b1, 8'h9f};
            default:  r = 9'd0;
         endcase
      end
      return r;
   endfunction

endpackage

// ----- rtl/cp_moji_if.sv -----
// Valid/ready channel interfaces for request and response beats.
interface cp_moji_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        last_unit;

   modport source (output valid, output code_unit, output last_unit, input ready);
   modport sink   (input valid, input code_unit, input last_unit, output ready);
endinterface

interface cp_moji_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] out_unit;
   logic        is_status;
   logic        accepted;
   logic        last_result;

   modport source (output valid, output out_unit, output is_status, output accepted,
                   output last_result, input ready);
   modport sink   (input valid, input out_unit, input is_status, input accepted,
                   input last_result, output ready);
endinterface

// ----- rtl/cp1252_mojibake_utf8_to_utf16_top.sv -----
// Top level of the CP1252 mojibake repair transcoder (UTF-8 bytes to UTF-16).
//
//  channel | dir | payload                                        | beat
//  req_if  | in  | code_unit[15:0], last_unit                     | one input unit
//  rsp_if  | out | out_unit[15:0], is_status, accepted, last_result | one result
//
// Cycles: one req beat per cycle while the entry queue has room; decode of a
//   unit is combinational in the front end.
// Responses: one beat per cycle while rsp_if.ready is high; a unit yields 0 to 3 beats
//   (up to two UTF-16 units plus the status on last_unit), so output rate bounds throughput.
// Path: a taken unit's entry is registered in the queue; beats come from the queue head.
// Stalls: rsp_if.ready low fills the queue (QUEUE_DEPTH entries), then req_if.ready drops.
// Reset: synchronous, active high; clears decoder state, queue pointers and back index.

module cp1252_mojibake_utf8_to_utf16_top #(
   parameter int QUEUE_DEPTH = cp_moji_pkg::QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   cp_moji_req_if.sink   req_if,
   cp_moji_rsp_if.source rsp_if
);

   cp_moji_pkg::entry_type wr_entry;
   cp_moji_pkg::entry_type head;
   logic                   push;
   logic                   pop;
   logic                   full;
   logic                   empty;

   // front: classify and decode each unit, build one queue entry
   cp_moji_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_if.valid),
      .code_unit  (req_if.code_unit),
      .last_unit  (req_if.last_unit),
      .queue_full (full),
      .in_ready   (req_if.ready),
      .push       (push),
      .entry      (wr_entry)
   );

   // decouples decode from response backpressure
   cp_moji_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .wr_entry (wr_entry),
      .pop      (pop),
      .head     (head),
      .full     (full),
      .empty    (empty)
   );

   // back: serialize entry into response beats
   cp_moji_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .empty  (empty),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

endmodule

// ----- rtl/cp_moji_front.sv -----
// Front end: byte recovery, strict UTF-8 decode, entry build.
`include "cp1252_mojibake_utf8_to_utf16_top_defines.svh"

module cp_moji_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [15:0]            code_unit,
   input  logic                   last_unit,
   input  logic                   queue_full,
   output logic                   in_ready,
   output logic                   push,
   output cp_moji_pkg::entry_type entry
);

   logic [20:0] pv_ff, pv_in;
   logic [1:0]  cl_ff, cl_in;
   logic [2:0]  ss_ff, ss_in;
   logic        sm_ff, sm_in;
   logic        sf_ff, sf_in;

   logic [8:0]  map;
   logic [7:0]  b;
   logic [20:0] acc;
   logic [20:0] cp;
   logic [20:0] v;
   logic        emit;
   logic        bad;
   logic        status_acc;
   logic        accept;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;
   assign map      = cp_moji_pkg::unit_to_byte(code_unit);
   assign b        = map[7:0];
   assign acc      = {pv_ff[14:0], b[5:0]};

   always_comb begin
      pv_in = pv_ff;
      cl_in = cl_ff;
      ss_in = ss_ff;
      sm_in = sm_ff;
      sf_in = sf_ff;
      emit  = 1'b0;
      cp    = '0;
      bad   = 1'b0;
      if (!sf_ff) begin
         if (!map[8]) begin
            sf_in = 1'b1;
         end else if (cl_ff == 2'd0) begin
            priority if (b[7] == 1'b0) begin
               emit = 1'b1;
               cp   = {13'd0, b};
            end else if (b >= cp_moji_pkg::LEAD2_MIN && b <= cp_moji_pkg::LEAD2_MAX) begin
               pv_in = {16'd0, b[4:0]};
               ss_in = cp_moji_pkg::SEQ_SIZE_2;
               cl_in = 2'd1;
               sm_in = 1'b1;
            end else if (b >= cp_moji_pkg::LEAD3_MIN && b <= cp_moji_pkg::LEAD3_MAX) begin
               pv_in = {17'd0, b[3:0]};
               ss_in = cp_moji_pkg::SEQ_SIZE_3;
               cl_in = 2'd2;
               sm_in = 1'b1;
            end else if (b >= cp_moji_pkg::LEAD4_MIN && b <= cp_moji_pkg::LEAD4_MAX) begin
               pv_in = {18'd0, b[2:0]};
               ss_in = cp_moji_pkg::SEQ_SIZE_4;
               cl_in = 2'd3;
               sm_in = 1'b1;
            end else begin
               sf_in = 1'b1;
            end
         end else if (b[7:6] != 2'b10) begin
            sf_in = 1'b1;
         end else begin
            pv_in = acc;
            cl_in = cl_ff - 2'd1;
            if (cl_ff == 2'd1) begin
               bad = (ss_ff == cp_moji_pkg::SEQ_SIZE_3 && acc < cp_moji_pkg::MIN_3BYTE) ||
                     (ss_ff == cp_moji_pkg::SEQ_SIZE_4 && acc < cp_moji_pkg::MIN_4BYTE) ||
                     (acc >= cp_moji_pkg::SURR_LO && acc <= cp_moji_pkg::SURR_HI) ||
                     (acc > cp_moji_pkg::MAX_POINT);
               if (bad) begin
                  sf_in = 1'b1;
               end else begin
                  emit = 1'b1;
                  cp   = acc;
               end
            end
         end
      end
      // truncated sequence at end of string rejects
      status_acc = !(sf_in || cl_in != 2'd0) && sm_in;
      if (last_unit) begin
         pv_in = '0;
         cl_in = '0;
         ss_in = '0;
         sm_in = 1'b0;
         sf_in = 1'b0;
      end
   end

   // surrogate pair split
   assign v = cp - cp_moji_pkg::MIN_4BYTE;

   always_comb begin
      entry            = '0;
      entry.has_status = last_unit;
      entry.accepted   = last_unit && status_acc;
      if (emit) begin
         if (cp[20:16] == 5'd0) begin
            entry.n_units = 2'd1;
            entry.unit0   = cp[15:0];
         end else begin
            entry.n_units = 2'd2;
            entry.unit0   = cp_moji_pkg::HI_SURR_BASE + {6'd0, v[19:10]};
            entry.unit1   = cp_moji_pkg::LO_SURR_BASE + {6'd0, v[9:0]};
         end
      end
   end

   assign push = accept && (emit || last_unit);

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= '0;
         cl_ff <= '0;
         ss_ff <= '0;
         sm_ff <= 1'b0;
         sf_ff <= 1'b0;
      end else if (accept) begin
         pv_ff <= pv_in;
         cl_ff <= cl_in;
         ss_ff <= ss_in;
         sm_ff <= sm_in;
         sf_ff <= sf_in;
      end
   end

   `CPM_ASSERT_NEXT(a_end_clears, accept && last_unit,
                    cl_ff == 2'd0 && !sf_ff && !sm_ff,
                    "front: state not cleared after end of string")
   `CPM_ASSERT_IMPL(a_open_seq_multi, cl_ff != 2'd0, sm_ff,
                    "front: open sequence without multibyte flag")

endmodule

// ----- rtl/cp_moji_queue.sv -----
// Small FIFO of decoded entries between front and back.
`include "cp1252_mojibake_utf8_to_utf16_top_defines.svh"

module cp_moji_queue #(
   parameter int DEPTH = cp_moji_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  cp_moji_pkg::entry_type wr_entry,
   input  logic                   pop,
   output cp_moji_pkg::entry_type head,
   output logic                   full,
   output logic                   empty
);

   localparam int AW = $clog2(DEPTH);

   cp_moji_pkg::entry_type mem [DEPTH];
   logic [AW:0] wr_ptr_ff, rd_ptr_ff;

   assign empty = (wr_ptr_ff == rd_ptr_ff);
   assign full  = (wr_ptr_ff[AW] != rd_ptr_ff[AW]) &&
                  (wr_ptr_ff[AW-1:0] == rd_ptr_ff[AW-1:0]);
   assign head  = mem[rd_ptr_ff[AW-1:0]];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff[AW-1:0]] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   `CPM_ASSERT_IMPL(a_no_overflow, push, !full, "queue: push while full")
   `CPM_ASSERT_ALWAYS(a_count_range, (wr_ptr_ff - rd_ptr_ff) <= (AW+1)'(DEPTH),
                      "queue: fill count out of range")

endmodule

// ----- rtl/cp_moji_back.sv -----
// Back end: walks each queued entry out as one response beat per result.
`include "cp1252_mojibake_utf8_to_utf16_top_defines.svh"

module cp_moji_back (
   input  logic                   clock,
   input  logic                   reset,
   input  cp_moji_pkg::entry_type head,
   input  logic                   empty,
   output logic                   pop,
   cp_moji_rsp_if.source          rsp_if
);

   logic [1:0] idx_ff, idx_in;
   logic [1:0] total;
   logic       last;
   logic       fire;

   assign total = head.n_units + {1'b0, head.has_status};
   assign last  = (idx_ff == total - 2'd1);
   assign fire  = rsp_if.valid && rsp_if.ready;
   assign pop   = fire && last;

   assign rsp_if.valid       = !empty;
   assign rsp_if.last_result = last;

   always_comb begin
      if (idx_ff < head.n_units) begin
         rsp_if.out_unit  = (idx_ff == 2'd0) ? head.unit0 : head.unit1;
         rsp_if.is_status = 1'b0;
         rsp_if.accepted  = 1'b0;
      end else begin
         rsp_if.out_unit  = '0;
         rsp_if.is_status = 1'b1;
         rsp_if.accepted  = head.accepted;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (fire) begin
         idx_in = last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   `CPM_ASSERT_IMPL(a_idx_in_entry, rsp_if.valid, idx_ff < total, "back: result index past entry")

endmodule
